FILE: design/assert_macros.svh
// assertion macros shared by the keyed value table modules
// no dependencies; each macro expects aclk in scope, KVT_ASSERT also aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define KVT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("keyed value table assertion failed");

// checked at every edge, reset included
`define KVT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("keyed value table assertion failed");

`endif

FILE: design/kvt_pkg.sv
// shared codes and controller/datapath interface structs for the keyed value table
// no dependencies
package kvt_pkg;

    // request codes
    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // table write operations
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_UPDATE = 2'd1;
    localparam logic [1:0] WR_APPEND = 2'd2;
    localparam logic [1:0] WR_SHIFT  = 2'd3;

    // entry count operations
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    localparam int WORD_W = 32;

    typedef logic [1:0]        req_t;
    typedef logic [1:0]        status_t;
    typedef logic [WORD_W-1:0] word_t;

    // controller to datapath
    typedef struct packed {
        logic       req_load;     // capture request, restart sweep at slot zero
        logic       step;         // advance read sweep by one slot
        logic       shift_start;  // restart sweep just above the matched slot
        logic [1:0] wr_op;
        logic [1:0] cnt_op;
        logic       res_load;
        status_t    res_status;
        logic       res_take_val; // result value from the matched slot
        logic       out_load;     // move result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_vld;   // read data of one slot is on hand
        logic match;      // that slot holds the request key
        logic sweep_done; // all slots up to the count have been read
        logic full;       // count at capacity
        req_t req_type;
    } sts_t;

endpackage

FILE: design/kvt_ctrl.sv
// controller state machine for the keyed value table
// depends on kvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module kvt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  kvt_pkg::sts_t st,
    output kvt_pkg::cmd_t cmd
);
    import kvt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.wr_op    = WR_NONE;
        cmd.cnt_op   = CNT_HOLD;
        cmd.res_status = ST_NOT_FOUND;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.step = 1'b1;
                if (st.match) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                    case (st.req_type)
                        REQ_SET: begin
                            cmd.wr_op      = WR_UPDATE;
                            cmd.res_status = ST_OK;
                        end
                        REQ_REMOVE: begin
                            cmd.res_load    = 1'b0;
                            cmd.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end
                        REQ_QUERY: begin
                            cmd.res_status   = ST_OK;
                            cmd.res_take_val = 1'b1;
                        end
                        default: cmd.res_status = ST_NOT_FOUND;
                    endcase
                end else if (st.sweep_done) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                    if (st.req_type == REQ_SET) begin
                        if (st.full) begin
                            cmd.res_status = ST_FULL;
                        end else begin
                            cmd.wr_op      = WR_APPEND;
                            cmd.cnt_op     = CNT_INC;
                            cmd.res_status = ST_OK;
                        end
                    end
                end
            end
            S_SHIFT: begin
                cmd.step = 1'b1;
                if (st.pipe_vld) begin
                    cmd.wr_op = WR_SHIFT;
                end
                if (st.sweep_done) begin
                    cmd.cnt_op     = CNT_DEC;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `KVT_ASSERT(a_accept_starts_search, accept |=> (state_reg == S_SEARCH))
    `KVT_ASSERT(a_shift_only_remove, (state_reg == S_SHIFT) |-> (st.req_type == REQ_REMOVE))
    `KVT_ASSERT(a_resp_leaves_beat, ($past(state_reg) == S_RESP && state_reg == S_IDLE) |-> m_valid_reg)

endmodule

FILE: design/kvt_dp.sv
// datapath for the keyed value table: key and value memories, sweep counter,
// entry count, request, result and output registers; depends on kvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module kvt_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kvt_pkg::cmd_t         cmd,
    output kvt_pkg::sts_t         st,
    input  kvt_pkg::req_t         s_req_type,
    input  kvt_pkg::word_t        s_key,
    input  kvt_pkg::word_t        s_value,
    output kvt_pkg::status_t      m_status,
    output kvt_pkg::word_t        m_read_value
);
    import kvt_pkg::*;

    localparam int IW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int MEM_DEPTH = 1 << IW;

    word_t key_mem [MEM_DEPTH];
    word_t val_mem [MEM_DEPTH];

    req_t    req_type_reg;
    word_t   key_reg, value_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0] prev_idx;
    logic          pipe_vld_reg, pipe_vld_next;
    word_t   key_rd_reg, val_rd_reg;
    status_t res_status_reg;
    word_t   res_value_reg;
    status_t m_status_reg;
    word_t   m_read_value_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    word_t         wr_key, wr_val;

    assign prev_idx = cmp_idx_reg - CW'(1);

    // sweep pointer and one-deep read pipeline
    always_comb begin
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        pipe_vld_next = 1'b0;
        if (cmd.req_load) begin
            rd_idx_next = '0;
        end else if (cmd.shift_start) begin
            rd_idx_next = cmp_idx_reg + CW'(1);
        end else if (cmd.step && rd_idx_reg != count_reg) begin
            rd_idx_next   = rd_idx_reg + CW'(1);
            cmp_idx_next  = rd_idx_reg;
            pipe_vld_next = 1'b1;
        end
    end

    always_comb begin
        count_next = count_reg;
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cmp_idx_reg[IW-1:0];
        wr_key  = key_reg;
        wr_val  = value_reg;
        unique case (cmd.wr_op)
            WR_UPDATE: wr_addr = cmp_idx_reg[IW-1:0];
            WR_APPEND: wr_addr = count_reg[IW-1:0];
            WR_SHIFT: begin
                wr_addr = prev_idx[IW-1:0];
                wr_key  = key_rd_reg;
                wr_val  = val_rd_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        key_rd_reg <= key_mem[rd_idx_reg[IW-1:0]];
        val_rd_reg <= val_mem[rd_idx_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            cmp_idx_reg  <= '0;
            pipe_vld_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            cmp_idx_reg  <= cmp_idx_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_type_reg <= s_req_type;
            key_reg      <= s_key;
            value_reg    <= s_value;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_take_val ? val_rd_reg : '0;
        end
        if (cmd.out_load) begin
            m_status_reg     <= res_status_reg;
            m_read_value_reg <= res_value_reg;
        end
    end

    assign st.pipe_vld   = pipe_vld_reg;
    assign st.match      = pipe_vld_reg && (key_rd_reg == key_reg);
    assign st.sweep_done = !pipe_vld_reg && (rd_idx_reg == count_reg);
    assign st.full       = (count_reg == CW'(CAPACITY));
    assign st.req_type   = req_type_reg;

    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;

    `KVT_ASSERT_ALWAYS(a_count_in_range, !aresetn || $past(!aresetn) || count_reg <= CW'(CAPACITY))
    `KVT_ASSERT(a_inc_not_full, (cmd.cnt_op == CNT_INC) |-> !st.full)
    `KVT_ASSERT(a_shift_has_data, (cmd.wr_op == WR_SHIFT) |-> (pipe_vld_reg && cmp_idx_reg != '0))

endmodule

FILE: design/keyed_value_table.sv
// keyed value table top level: joins the controller and the datapath
// depends on kvt_pkg, kvt_ctrl and kvt_dp
//
// A packed table of up to CAPACITY 32-bit key/value pairs held in slots
// 0 .. count-1 of two single-port-write memories. Each input beat is a set,
// a remove or a query and gives exactly one result beat. Requests are served
// one at a time: a linear sweep reads one slot per cycle through the memory
// read port until it hits the key or has read all entries, and a remove
// goes on from its hit (the search stops at the matched slot, then the
// shift-down reads the entries above it and moves one per cycle through
// the same read and write ports). A new request is taken as soon as the
// previous one has reached the output register, even if that result beat
// still waits for m_ready. Set of a new key on a full table answers status
// full, remove or query of an absent key answers not found, the reserved
// request code changes nothing and answers not found; read_value is zero
// except on a successful query. After reset the table is empty; no
// clearing pass.
module keyed_value_table #(
    parameter int CAPACITY = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kvt_pkg::req_t         s_req_type,
    input  kvt_pkg::word_t        s_key,
    input  kvt_pkg::word_t        s_value,
    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output kvt_pkg::status_t      m_status,
    output kvt_pkg::word_t        m_read_value
);
    import kvt_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t st;

    // sequencer: idle, search sweep, shift-down, result hand-off
    kvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // memories, sweep pointer, entry count and output register
    kvt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .s_req_type   (s_req_type),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_status     (m_status),
        .m_read_value (m_read_value)
    );

endmodule

FILE: bench/kvt_checker.sv
// result checker for the keyed value table: tracks the table contents from
// accepted request beats and compares every result beat; depends on kvt_pkg
module kvt_checker #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  kvt_pkg::req_t    s_req_type,
    input  kvt_pkg::word_t   s_key,
    input  kvt_pkg::word_t   s_value,
    input  logic             m_valid,
    input  logic             m_ready,
    input  kvt_pkg::status_t m_status,
    input  kvt_pkg::word_t   m_read_value,
    output int               mismatches,
    output int               results_owed,
    output int               requests_seen,
    output int               results_seen,
    output int               full_answers,
    output int               query_hits
);
    import kvt_pkg::*;

    typedef struct packed {
        status_t status;
        word_t   read_value;
    } answer_t;

    word_t   key_store [CAPACITY];
    word_t   value_store [CAPACITY];
    int      live_entries;
    answer_t owed_answers [$];

    // applies one request to the shadow table and returns its answer
    function automatic answer_t serve_request(input req_t req, input word_t key,
                                              input word_t value);
        answer_t ans;
        int      slot;
        ans.status     = ST_NOT_FOUND;
        ans.read_value = '0;
        slot           = -1;
        for (int i = 0; i < live_entries; i++) begin
            if (slot < 0 && key_store[i] === key) slot = i;
        end
        case (req)
            REQ_SET: begin
                if (slot >= 0) begin
                    value_store[slot] = value;
                    ans.status = ST_OK;
                end else if (live_entries < CAPACITY) begin
                    key_store[live_entries]   = key;
                    value_store[live_entries] = value;
                    live_entries++;
                    ans.status = ST_OK;
                end else begin
                    ans.status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (slot >= 0) begin
                    for (int i = slot; i < live_entries - 1; i++) begin
                        key_store[i]   = key_store[i + 1];
                        value_store[i] = value_store[i + 1];
                    end
                    live_entries--;
                    ans.status = ST_OK;
                end
            end
            REQ_QUERY: begin
                if (slot >= 0) begin
                    ans.read_value = value_store[slot];
                    ans.status = ST_OK;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            live_entries  = 0;
            mismatches    = 0;
            results_owed  = 0;
            requests_seen = 0;
            results_seen  = 0;
            full_answers  = 0;
            query_hits    = 0;
            owed_answers.delete();
        end else begin
            // result side first: a result never belongs to a request taken at the same edge
            if (m_valid && m_ready) begin
                results_seen++;
                if (owed_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: unexpected result beat, status %0d read_value %h",
                                 m_status, m_read_value);
                end else begin
                    want = owed_answers.pop_front();
                    if (m_status !== want.status || m_read_value !== want.read_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("checker: result %0d: status exp %0d got %0d, %s%h got %h",
                                     results_seen, want.status, m_status,
                                     "read_value exp ", want.read_value, m_read_value);
                    end
                    if (want.status == ST_FULL) full_answers++;
                end
            end
            if (s_valid && s_ready) begin
                requests_seen++;
                want = serve_request(s_req_type, s_key, s_value);
                if (s_req_type == REQ_QUERY && want.status == ST_OK) query_hits++;
                owed_answers.push_back(want);
            end
            results_owed = owed_answers.size();
        end
    end

endmodule

FILE: bench/keyed_value_table_tb.sv
// top level testbench for keyed_value_table: clock, reset, request stimulus
// and verdict; depends on kvt_pkg, keyed_value_table and kvt_checker
module keyed_value_table_tb;
    import kvt_pkg::*;

    localparam int   CAPACITY    = 16;
    // the reserved request code has no name in the package
    localparam req_t REQ_RESERVED = 2'd3;
    localparam int   PHASES       = 4;
    localparam int   PHASE_ITEMS  = 330;
    localparam int   POOL_SIZE    = 24;
    // a remove reads each of at most CAPACITY slots once, so this is generous
    localparam int   DRAIN_CYCLES = 64;
    localparam int   QUIET_LIMIT  = 4000;

    // sender idle and receiver stall odds per phase, in percent
    localparam int SEND_IDLE [PHASES]  = '{0, 71, 0, 21};
    localparam int RECV_STALL [PHASES] = '{0, 0, 71, 21};

    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    req_t    s_req_type;
    word_t   s_key;
    word_t   s_value;
    logic    m_valid;
    logic    m_ready = 1'b0;
    status_t m_status;
    word_t   m_read_value;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    int mismatches;
    int results_owed;
    int requests_seen;
    int results_seen;
    int full_answers;
    int query_hits;

    keyed_value_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_value(m_read_value)
    );

    kvt_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .mismatches   (mismatches),
        .results_owed (results_owed),
        .requests_seen(requests_seen),
        .results_seen (results_seen),
        .full_answers (full_answers),
        .query_hits   (query_hits)
    );

    // 10 unit clock period
    always #5 aclk = ~aclk;

    // result side backpressure, re-rolled every cycle at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: too many cycles without a beat on either channel means a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles, %0d results still owed",
                             quiet_cycles, results_owed);
                    $display("keyed_value_table_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    // one request beat: optional idle cycles, then hold valid until accepted;
    // returns at the accepting rising edge
    task automatic send_beat(input req_t req, input word_t key, input word_t value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_key      <= key;
        s_value    <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        word_t key_pool [POOL_SIZE];
        word_t fill_key;
        mix_t  mix;
        req_t  op;
        word_t pick_key;
        int    roll;
        int    episode_left;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_SET;
        s_key          = '0;
        s_value        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        episode_left   = 0;
        mix            = MIX_EVEN;

        // synchronous reset held low, then released at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling on either side
        // requests against an empty table, reserved code with all ones
        send_beat(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
        send_beat(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(REQ_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // fill every slot: extreme keys and values first, then distinct keys
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0)
                send_beat(REQ_SET, 32'h0000_0000, 32'hFFFF_FFFF);
            else if (i == 1)
                send_beat(REQ_SET, 32'hFFFF_FFFF, 32'h0000_0000);
            else begin
                fill_key = 32'h1000_0001 * i;
                send_beat(REQ_SET, fill_key, $urandom);
            end
        end

        // new key on a full table, then update of a key that is present
        send_beat(REQ_SET, 32'h5A5A_A5A5, 32'h1234_5678);
        send_beat(REQ_SET, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_beat(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
        send_beat(REQ_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
        // remove from slot zero shifts the whole table down
        send_beat(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_beat(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
        // reserved code on a present key must leave it alone
        send_beat(REQ_RESERVED, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(REQ_REMOVE, 32'h5A5A_A5A5, 32'h0000_0000);

        // key pool for the random part; extremes stay in it throughout
        foreach (key_pool[j]) key_pool[j] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        // random part: episodes that lean toward filling, draining or neither,
        // so the table swings between empty and full; keys mostly from the pool
        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (episode_left == 0) begin
                    episode_left = $urandom_range(20, 60);
                    mix = mix_t'($urandom_range(2));
                    // retire a few pool keys so stale entries drift out slowly
                    repeat (3) key_pool[$urandom_range(POOL_SIZE - 1, 2)] = $urandom;
                end
                episode_left--;
                roll = $urandom_range(99);
                case (mix)
                    MIX_FILL: begin
                        op = roll < 65 ? REQ_SET : roll < 77 ? REQ_REMOVE :
                             roll < 97 ? REQ_QUERY : REQ_RESERVED;
                    end
                    MIX_DRAIN: begin
                        op = roll < 20 ? REQ_SET : roll < 70 ? REQ_REMOVE :
                             roll < 97 ? REQ_QUERY : REQ_RESERVED;
                    end
                    default: begin
                        op = roll < 40 ? REQ_SET : roll < 70 ? REQ_REMOVE :
                             roll < 97 ? REQ_QUERY : REQ_RESERVED;
                    end
                endcase
                // one in ten keys is fresh and almost surely absent
                if ($urandom_range(9) == 0)
                    pick_key = $urandom;
                else
                    pick_key = key_pool[$urandom_range(POOL_SIZE - 1)];
                send_beat(op, pick_key, $urandom);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // wait for every owed result, then watch a little longer for strays;
        // the watchdog bounds this wait
        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("summary: %0d requests and %0d results checked over %0d handshake phases",
                 requests_seen, results_seen, PHASES);
        $display("summary: %0d table-full answers, %0d successful queries, %0d mismatches",
                 full_answers, query_hits, mismatches);
        if (mismatches == 0 && results_owed == 0) begin
            $display("keyed_value_table_tb: done, clean");
        end else begin
            $display("keyed_value_table_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/kvt_pkg.sv
design/kvt_ctrl.sv
design/kvt_dp.sv
design/keyed_value_table.sv
bench/kvt_checker.sv
bench/keyed_value_table_tb.sv
